[rtl/core/vtesc_pkg.sv]
// vtesc_pkg: shared types and constants of the escape sequence parser.
// Parser state codes, action codes, sequence kinds and key C0/C1 bytes.
// No dependencies.
package vtesc_pkg;

    typedef logic [20:0] t_code;
    typedef logic [3:0]  t_action;
    typedef logic [3:0]  t_state;
    typedef logic [2:0]  t_kind;

    localparam t_state ST_GROUND     = 4'd0;
    localparam t_state ST_ESC        = 4'd1;
    localparam t_state ST_ESC_INTER  = 4'd2;
    localparam t_state ST_CSI_ENTRY  = 4'd3;
    localparam t_state ST_CSI_PARAM  = 4'd4;
    localparam t_state ST_CSI_INTER  = 4'd5;
    localparam t_state ST_CSI_IGNORE = 4'd6;
    localparam t_state ST_DCS_ENTRY  = 4'd7;
    localparam t_state ST_DCS_PARAM  = 4'd8;
    localparam t_state ST_DCS_INTER  = 4'd9;
    localparam t_state ST_DCS_PASS   = 4'd10;
    localparam t_state ST_DCS_IGNORE = 4'd11;
    localparam t_state ST_OSC        = 4'd12;
    localparam t_state ST_APC        = 4'd13;
    localparam t_state ST_SOS        = 4'd14;
    localparam t_state ST_STAY       = 4'd15;

    localparam t_action A_IGN     = 4'd0;
    localparam t_action A_CTL     = 4'd1;
    localparam t_action A_PRINT   = 4'd2;
    localparam t_action A_COLLECT = 4'd3;
    localparam t_action A_PARAM   = 4'd4;
    localparam t_action A_MODE    = 4'd5;
    localparam t_action A_FINAL   = 4'd6;
    localparam t_action A_PASS    = 4'd7;
    localparam t_action A_TEXT    = 4'd8;
    localparam t_action A_D_ESC   = 4'd9;
    localparam t_action A_D_CSI   = 4'd10;
    localparam t_action A_D_DCS   = 4'd11;
    localparam t_action A_D_OSC   = 4'd12;
    localparam t_action A_D_APC   = 4'd13;

    localparam t_kind K_NONE = 3'd0;

    localparam t_code C_BEL = 21'h07;
    localparam t_code C_CAN = 21'h18;
    localparam t_code C_SUB = 21'h1a;
    localparam t_code C_ESC = 21'h1b;
    localparam t_code C_DEL = 21'h7f;

    localparam logic [7:0] C1_DCS = 8'h90;
    localparam logic [7:0] C1_SOS = 8'h98;
    localparam logic [7:0] C1_CSI = 8'h9b;
    localparam logic [7:0] C1_ST  = 8'h9c;
    localparam logic [7:0] C1_OSC = 8'h9d;
    localparam logic [7:0] C1_PM  = 8'h9e;

    typedef struct packed {
        t_action action;
        t_state  next_state;
        t_kind   kind;
        logic    seq_start;
    } t_dec_res;

    typedef struct packed {
        logic [7:0]      final_byte;
        logic [7:0]      private_marker;
        logic [3:0][7:0] inter;
        logic [2:0]      count;
    } t_seq_view;

endpackage

[rtl/core/vtesc_decode.sv]
// vtesc_decode: per-state classification of one character code.
// Gives the action, the following state, the sequence kind and the clearing flag.
// Depends on vtesc_pkg.
module vtesc_decode (
    input  vtesc_pkg::t_state   i_state,
    input  vtesc_pkg::t_code    i_code,
    output vtesc_pkg::t_dec_res o_res
);
    import vtesc_pkg::*;

    t_state  st;
    t_state  nx;
    t_state  nst;
    t_action act;
    logic    lo;
    logic    p_inter;
    logic    p_par;
    logic    p_mode;
    logic    p_hi;
    logic    clearing;

    always_comb begin
        st      = (i_state > ST_SOS) ? ST_GROUND : i_state;
        act     = A_IGN;
        nx      = ST_STAY;
        lo      = (st <= ST_CSI_IGNORE);
        p_inter = (i_code <= 21'h2f);
        p_par   = (i_code >= 21'h30) && (i_code <= 21'h3b);
        p_mode  = (i_code >= 21'h3c) && (i_code <= 21'h3f);
        p_hi    = (i_code >= 21'h40);

        priority if (i_code >= 21'ha0) begin
            if (st == ST_GROUND) begin
                act = A_PRINT;
            end else if (st == ST_OSC) begin
                act = A_TEXT;
            end
        end else if (i_code >= 21'h80) begin
            if (i_code <= 21'h8f || (i_code >= 21'h91 && i_code <= 21'h97) ||
                i_code == 21'h99 || i_code == 21'h9a) begin
                act = A_CTL;
                nx  = (st == ST_GROUND) ? ST_STAY : ST_GROUND;
            end else begin
                unique case (i_code[7:0])
                    C1_DCS: nx = (st == ST_DCS_ENTRY) ? ST_STAY : ST_DCS_ENTRY;
                    C1_SOS: nx = (st == ST_SOS) ? ST_STAY : ST_SOS;
                    C1_CSI: nx = (st == ST_CSI_ENTRY) ? ST_STAY : ST_CSI_ENTRY;
                    C1_ST: begin
                        if (st == ST_DCS_PASS) begin
                            act = A_D_DCS;
                            nx  = ST_GROUND;
                        end else if (st == ST_OSC) begin
                            act = A_D_OSC;
                            nx  = ST_GROUND;
                        end else if (st == ST_APC) begin
                            act = A_D_APC;
                            nx  = ST_GROUND;
                        end else if (st == ST_DCS_IGNORE || st == ST_SOS) begin
                            nx = ST_GROUND;
                        end
                    end
                    C1_OSC: begin
                        if (st != ST_OSC && st != ST_APC) begin
                            nx = ST_OSC;
                        end
                    end
                    C1_PM: begin
                        if (st != ST_SOS) begin
                            nx = ST_SOS;
                        end
                    end
                    default: nx = ST_APC;
                endcase
            end
        end else if (i_code == C_CAN || i_code == C_SUB) begin
            act = A_CTL;
            if (st != ST_GROUND) begin
                nx = ST_GROUND;
            end
        end else if (i_code == C_ESC) begin
            if (st == ST_DCS_PASS) begin
                act = A_D_DCS;
            end else if (st == ST_OSC) begin
                act = A_D_OSC;
            end else if (st == ST_APC) begin
                act = A_D_APC;
            end
            if (st != ST_ESC) begin
                nx = ST_ESC;
            end
        end else if (i_code < 21'h20) begin
            if (i_code == C_BEL && (st == ST_OSC || st == ST_APC)) begin
                act = (st == ST_OSC) ? A_D_OSC : A_D_APC;
                nx  = ST_GROUND;
            end else if (lo) begin
                act = A_CTL;
            end else if (st == ST_DCS_PASS) begin
                act = A_PASS;
            end
        end else if (i_code == C_DEL) begin
            if (lo || (st >= ST_DCS_ENTRY && st <= ST_DCS_PASS)) begin
                act = A_CTL;
            end else if (st == ST_OSC || st == ST_APC) begin
                act = A_TEXT;
            end
        end else begin
            unique case (st)
                ST_GROUND: act = A_PRINT;
                ST_ESC: begin
                    priority if (p_inter) begin
                        act = A_COLLECT;
                        nx  = ST_ESC_INTER;
                    end else if (i_code == 21'h50) begin
                        nx = ST_DCS_ENTRY;
                    end else if (i_code == 21'h58 || i_code == 21'h5e) begin
                        nx = ST_SOS;
                    end else if (i_code == 21'h5b) begin
                        nx = ST_CSI_ENTRY;
                    end else if (i_code == 21'h5d) begin
                        nx = ST_OSC;
                    end else if (i_code == 21'h5f) begin
                        nx = ST_APC;
                    end else begin
                        act = A_D_ESC;
                        nx  = ST_GROUND;
                    end
                end
                ST_ESC_INTER: begin
                    if (p_inter) begin
                        act = A_COLLECT;
                    end else begin
                        act = A_D_ESC;
                        nx  = ST_GROUND;
                    end
                end
                ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INTER: begin
                    priority if (p_inter) begin
                        act = A_COLLECT;
                        if (st != ST_CSI_INTER) begin
                            nx = ST_CSI_INTER;
                        end
                    end else if (p_hi) begin
                        act = A_D_CSI;
                        nx  = ST_GROUND;
                    end else if (st == ST_CSI_INTER) begin
                        nx = ST_CSI_IGNORE;
                    end else if (p_par) begin
                        act = A_PARAM;
                        if (st == ST_CSI_ENTRY) begin
                            nx = ST_CSI_PARAM;
                        end
                    end else if (p_mode && st == ST_CSI_ENTRY) begin
                        act = A_MODE;
                        nx  = ST_CSI_PARAM;
                    end else begin
                        nx = ST_CSI_IGNORE;
                    end
                end
                ST_CSI_IGNORE: begin
                    if (p_hi) begin
                        nx = ST_GROUND;
                    end
                end
                ST_DCS_ENTRY, ST_DCS_PARAM, ST_DCS_INTER: begin
                    priority if (p_inter) begin
                        act = A_COLLECT;
                        if (st != ST_DCS_INTER) begin
                            nx = ST_DCS_INTER;
                        end
                    end else if (p_hi) begin
                        act = A_FINAL;
                        nx  = ST_DCS_PASS;
                    end else if (st == ST_DCS_INTER) begin
                        nx = ST_DCS_IGNORE;
                    end else if (p_par) begin
                        act = A_PARAM;
                        if (st == ST_DCS_ENTRY) begin
                            nx = ST_DCS_PARAM;
                        end
                    end else if (p_mode && st == ST_DCS_ENTRY) begin
                        act = A_MODE;
                        nx  = ST_DCS_PARAM;
                    end else begin
                        nx = ST_DCS_IGNORE;
                    end
                end
                ST_DCS_PASS: act = A_PASS;
                ST_OSC, ST_APC: act = A_TEXT;
                default: act = A_IGN;
            endcase
        end

        nst      = (nx == ST_STAY) ? st : nx;
        clearing = (nx == ST_ESC) || (nx == ST_CSI_ENTRY) || (nx == ST_DCS_ENTRY) ||
                   (nx == ST_OSC) || (nx == ST_APC) || (nx == ST_SOS);

        o_res.action     = act;
        o_res.next_state = nst;
        o_res.kind       = (act >= A_D_ESC) ? 3'(act - A_D_ESC) : K_NONE;
        o_res.seq_start  = clearing;
    end

endmodule

[rtl/core/vtesc_seq_store.sv]
// vtesc_seq_store: held final byte, private marker and intermediates.
// Shows the values after this beat's action; clears on entry states.
// Depends on vtesc_pkg.
module vtesc_seq_store #(
    parameter int MAX_INTERMEDIATES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  vtesc_pkg::t_action   i_action,
    input  logic [7:0]           i_byte,
    input  logic                 i_clear,
    output vtesc_pkg::t_seq_view o_view
);
    import vtesc_pkg::*;

    localparam int CW = $clog2(MAX_INTERMEDIATES + 1);

    logic [7:0]    r_final;
    logic [7:0]    r_marker;
    logic [7:0]    r_inter [MAX_INTERMEDIATES];
    logic [CW-1:0] r_count;

    logic [7:0]    n_final;
    logic [7:0]    n_marker;
    logic [7:0]    n_inter [MAX_INTERMEDIATES];
    logic [CW-1:0] n_count;
    logic          w_room;
    logic          w_collect;
    logic [31:0]   w_count_wide;

    assign w_room    = (r_count < CW'(MAX_INTERMEDIATES));
    assign w_collect = (i_action == A_COLLECT) && w_room;

    always_comb begin
        n_final  = r_final;
        n_marker = r_marker;
        if (i_action == A_MODE) begin
            n_marker = i_byte;
        end
        if (i_action == A_FINAL || i_action == A_D_ESC || i_action == A_D_CSI) begin
            n_final = i_byte;
        end
        n_count = w_collect ? r_count + CW'(1) : r_count;
    end

    for (genvar g = 0; g < MAX_INTERMEDIATES; g++) begin : g_slot
        assign n_inter[g] = (w_collect && r_count == CW'(g)) ? i_byte : r_inter[g];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_inter[g] <= 8'h00;
            end else if (i_step) begin
                r_inter[g] <= i_clear ? 8'h00 : n_inter[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final  <= 8'h00;
            r_marker <= 8'h00;
            r_count  <= '0;
        end else if (i_step) begin
            r_final  <= i_clear ? 8'h00 : n_final;
            r_marker <= i_clear ? 8'h00 : n_marker;
            r_count  <= i_clear ? '0 : n_count;
        end
    end

    assign w_count_wide = {{(32 - CW){1'b0}}, n_count};

    for (genvar k = 0; k < 4; k++) begin : g_view
        if (k < MAX_INTERMEDIATES) begin : g_held
            assign o_view.inter[k] = (w_count_wide > k) ? n_inter[k] : 8'h00;
        end else begin : g_none
            assign o_view.inter[k] = 8'h00;
        end
    end

    assign o_view.final_byte     = n_final;
    assign o_view.private_marker = n_marker;
    assign o_view.count          = (w_count_wide > 32'd4) ? 3'd4 : w_count_wide[2:0];

endmodule

[rtl/core/vt_escape_sequence_parser_core.sv]
// vt_escape_sequence_parser_core: DEC/ANSI escape sequence parser, top level.
// Input register, per-state decode and sequence store, result register.
// Depends on vtesc_pkg, vtesc_decode, vtesc_seq_store.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+------------------------------------------
//  in       | i_in_valid  | o_in_ready  | i_code_point
//  out      | o_out_valid | i_out_ready | o_action .. o_sequence_start
//
// One character per cycle sustained while the output is not stalled.
// The parser state and held sequence update when an item moves from the input
// register into the result register, so the next item decodes against them.
// A stalled output holds the result register; the input register fills and then
// o_in_ready drops. Synchronous reset returns the parser to ground, all held bytes zero.
module vt_escape_sequence_parser_core #(
    parameter int MAX_INTERMEDIATES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vtesc_pkg::t_code   i_code_point,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vtesc_pkg::t_action o_action,
    output vtesc_pkg::t_code   o_char_out,
    output vtesc_pkg::t_kind   o_seq_kind,
    output logic [7:0]         o_final_byte,
    output logic [7:0]         o_private_marker,
    output logic [7:0]         o_inter_first,
    output logic [7:0]         o_inter_second,
    output logic [7:0]         o_inter_third,
    output logic [7:0]         o_inter_fourth,
    output logic [2:0]         o_inter_count,
    output logic               o_sequence_start
);
    import vtesc_pkg::*;

    logic      r_in_valid;
    t_code     r_in_code;
    t_state    r_state;
    logic      r_out_valid;
    t_action   r_action;
    t_code     r_char;
    t_kind     r_kind;
    t_seq_view r_view;
    logic      r_start;

    logic      w_adv;
    logic      w_step;
    t_dec_res  w_dec;
    t_seq_view w_view;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    vtesc_decode u_decode (
        .i_state (r_state),
        .i_code  (r_in_code),
        .o_res   (w_dec)
    );

    vtesc_seq_store #(
        .MAX_INTERMEDIATES (MAX_INTERMEDIATES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_action (w_dec.action),
        .i_byte   (r_in_code[7:0]),
        .i_clear  (w_dec.seq_start),
        .o_view   (w_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_GROUND;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_state <= w_dec.next_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_code <= i_code_point;
        end
        if (w_step) begin
            r_action <= w_dec.action;
            r_char   <= r_in_code;
            r_kind   <= w_dec.kind;
            r_view   <= w_view;
            r_start  <= w_dec.seq_start;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_action;
    assign o_char_out       = r_char;
    assign o_seq_kind       = r_kind;
    assign o_final_byte     = r_view.final_byte;
    assign o_private_marker = r_view.private_marker;
    assign o_inter_first    = r_view.inter[0];
    assign o_inter_second   = r_view.inter[1];
    assign o_inter_third    = r_view.inter[2];
    assign o_inter_fourth   = r_view.inter[3];
    assign o_inter_count    = r_view.count;
    assign o_sequence_start = r_start;

    a_state_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_state == $past(w_dec.next_state))
        else $error("parser state did not take decoded next state");

    a_kind_only_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action < A_D_ESC) |-> o_seq_kind == K_NONE)
        else $error("sequence kind set on a non-dispatch action");

    a_final_on_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == A_D_ESC || o_action == A_D_CSI ||
                         o_action == A_FINAL))
        |-> o_final_byte == o_char_out[7:0])
        else $error("final byte not captured on dispatch");

    a_collect_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == A_COLLECT) |-> o_inter_count != 3'd0)
        else $error("collect reported with no intermediates held");

    a_no_step_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_state))
        else $error("parser state moved without an item");

endmodule
